/* hw/rtl/gpea_pkg.sv */
// Package for the gamepad edge and auto-repeat block: widths, register
// indexes, button positions and small helper functions.
// Depends on nothing; every other file in hw/rtl uses it.
package gpea_pkg;

  // Width of each per-input hold counter (4 to 8 bits).
  localparam int unsigned HoldCntW = 4;

  localparam int unsigned NumButtons = 12;
  localparam int unsigned NumPhys    = 20;
  localparam int unsigned NumOut     = 22;
  localparam int unsigned AxisW      = 8;
  localparam int unsigned DelayW     = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 8;

  // Positions of the mapped buttons.
  localparam int unsigned IdxCircle = 7;
  localparam int unsigned IdxCross  = 8;
  localparam int unsigned IdxEnter  = 12;
  localparam int unsigned IdxCancel = 13;

  // Register reset values.
  localparam logic [AxisW-1:0]  AxisLowReset  = 8'd64;
  localparam logic [AxisW-1:0]  AxisHighReset = 8'd192;
  localparam logic [DelayW-1:0] DelayReset    = 4'd10;
  localparam logic [DelayW-1:0] ReloadReset   = 4'd6;

  typedef logic [HoldCntW-1:0] hold_cnt_t;
  typedef logic [NumOut-1:0]   out_vec_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_AXIS_LOW      = 3'd0,
    CFG_AXIS_HIGH     = 3'd1,
    CFG_REPEAT_DELAY  = 3'd2,
    CFG_REPEAT_RELOAD = 3'd3,
    CFG_ENTER_CIRCLE  = 3'd4
  } cfg_reg_e;

  // Repeat timing shared by all lanes.
  typedef struct packed {
    logic [DelayW-1:0] delay;
    logic [DelayW-1:0] reload;
  } rep_cfg_t;

  // Per-lane flags for one word.
  typedef struct packed {
    logic lvl;
    logic prs;
    logic rls;
    logic slw;
    logic fst;
  } lane_out_t;

  // One result word.
  typedef struct packed {
    out_vec_t level_bits;
    out_vec_t press_bits;
    out_vec_t release_bits;
    out_vec_t slow_repeat_bits;
    out_vec_t fast_repeat_bits;
  } res_t;

  // Thresholds one axis: bit 0 is up or left, bit 1 is down or right.
  // Below the low limit wins when the limits cross.
  function automatic logic [1:0] axis_dir(input logic [AxisW-1:0] v,
                                          input logic [AxisW-1:0] lo,
                                          input logic [AxisW-1:0] hi);
    logic [1:0] r;
    r = 2'b00;
    if (v < lo) begin
      r = 2'b01;
    end else if (v > hi) begin
      r = 2'b10;
    end
    return r;
  endfunction

  // Increment that sticks at all ones.
  function automatic hold_cnt_t sat_inc(input hold_cnt_t c);
    hold_cnt_t r;
    r = (c == '1) ? c : c + hold_cnt_t'(1);
    return r;
  endfunction

endpackage

/* hw/rtl/gpea_if.sv */
// Channel interfaces of the gamepad block: one for the sample words coming
// in and one for the result words going out. Depends on gpea_pkg.
interface gpea_in_if;
  logic                        valid;
  logic                        ready;
  logic [gpea_pkg::NumButtons-1:0] digital_buttons;
  logic [gpea_pkg::AxisW-1:0]  left_x;
  logic [gpea_pkg::AxisW-1:0]  left_y;
  logic [gpea_pkg::AxisW-1:0]  right_x;
  logic [gpea_pkg::AxisW-1:0]  right_y;

  modport source (output valid, digital_buttons, left_x, left_y, right_x, right_y,
                  input ready);
  modport sink (input valid, digital_buttons, left_x, left_y, right_x, right_y,
                output ready);
endinterface

interface gpea_out_if;
  logic                 valid;
  logic                 ready;
  gpea_pkg::out_vec_t   level_bits;
  gpea_pkg::out_vec_t   press_bits;
  gpea_pkg::out_vec_t   release_bits;
  gpea_pkg::out_vec_t   slow_repeat_bits;
  gpea_pkg::out_vec_t   fast_repeat_bits;

  modport source (output valid, level_bits, press_bits, release_bits,
                  slow_repeat_bits, fast_repeat_bits, input ready);
  modport sink (input valid, level_bits, press_bits, release_bits,
                slow_repeat_bits, fast_repeat_bits, output ready);
endinterface

/* hw/rtl/gpea_lane.sv */
// One physical input: edge detection and the slow and fast hold counters.
// Depends on gpea_pkg.
module gpea_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 cur_i,
  input  gpea_pkg::rep_cfg_t   cfg_i,
  output gpea_pkg::lane_out_t  res_o
);

  logic                 prev_q, prev_d;
  gpea_pkg::hold_cnt_t  slow_q, slow_d;
  gpea_pkg::hold_cnt_t  fast_q, fast_d;
  gpea_pkg::hold_cnt_t  delay_ext, reload_ext;
  logic                 slow_hit, fast_hit;

  assign delay_ext  = gpea_pkg::hold_cnt_t'(cfg_i.delay);
  assign reload_ext = gpea_pkg::hold_cnt_t'(cfg_i.reload);

  // A held input at or past the delay pulses and reloads its counter.
  assign slow_hit = cur_i && (slow_q >= delay_ext);
  assign fast_hit = cur_i && (fast_q >= delay_ext);

  always_comb begin
    prev_d = cur_i;
    if (cur_i) begin
      slow_d = gpea_pkg::sat_inc(slow_hit ? reload_ext : slow_q);
      fast_d = gpea_pkg::sat_inc(fast_hit ? delay_ext : fast_q);
    end else begin
      slow_d = '0;
      fast_d = '0;
    end
  end

  // Flags for the current word.
  always_comb begin
    res_o.lvl = cur_i;
    res_o.prs = cur_i && !prev_q;
    res_o.rls = !cur_i && prev_q;
    res_o.slw = res_o.prs || slow_hit;
    res_o.fst = res_o.prs || fast_hit;
  end

  // State moves only when a word is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      slow_q <= '0;
      fast_q <= '0;
    end else if (step_i) begin
      prev_q <= prev_d;
      slow_q <= slow_d;
      fast_q <= fast_d;
    end
  end

endmodule

/* hw/rtl/gamepad_edge_autorepeat.sv */
// Gamepad edge detector with auto-repeat: top level.
// Depends on gpea_pkg, gpea_in_if, gpea_out_if and gpea_lane.
//
// Usage:
//   in_i carries one controller sample word per frame (twelve buttons and
//   four stick axes); out_o carries one result word per sample, each field
//   22 bits wide with one bit per button index.
//   A word accepted on in_i is registered in the input register, processed
//   by the lanes and registered again in the result register that drives
//   out_o. One word per cycle is sustained while the receiver does not
//   stall, since each lane finishes its update in the single combinational
//   step between the input and result registers.
//   When the receiver stalls, the result word holds and one more word can
//   wait in the input register; ready then falls until the result leaves.
//   Reset clears both registers' valid flags, all previous levels and hold
//   counters, and loads the configuration registers with their defaults.
//   The cfg port writes one register per cycle with cfg_we_i, and unknown
//   indexes are ignored. The user must write only while no word is in flight; the block does not enforce it.
module gamepad_edge_autorepeat (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  gpea_in_if.sink                           in_i,
  gpea_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [gpea_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [gpea_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  // Configuration registers.
  logic [gpea_pkg::AxisW-1:0]  axis_lo_q, axis_hi_q;
  logic [gpea_pkg::DelayW-1:0] delay_q, reload_q;
  logic                        enter_circle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_lo_q      <= gpea_pkg::AxisLowReset;
      axis_hi_q      <= gpea_pkg::AxisHighReset;
      delay_q        <= gpea_pkg::DelayReset;
      reload_q       <= gpea_pkg::ReloadReset;
      enter_circle_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (gpea_pkg::cfg_reg_e'(cfg_idx_i))
        gpea_pkg::CFG_AXIS_LOW:      axis_lo_q      <= cfg_wdata_i;
        gpea_pkg::CFG_AXIS_HIGH:     axis_hi_q      <= cfg_wdata_i;
        gpea_pkg::CFG_REPEAT_DELAY:  delay_q        <= cfg_wdata_i[gpea_pkg::DelayW-1:0];
        gpea_pkg::CFG_REPEAT_RELOAD: reload_q       <= cfg_wdata_i[gpea_pkg::DelayW-1:0];
        gpea_pkg::CFG_ENTER_CIRCLE:  enter_circle_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register and handshake.
  logic                                in_vld_q;
  logic [gpea_pkg::NumButtons-1:0]     btn_q;
  logic [gpea_pkg::AxisW-1:0]          lx_q, ly_q, rx_q, ry_q;
  logic                                out_vld_q;
  logic                                advance;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      btn_q <= in_i.digital_buttons;
      lx_q  <= in_i.left_x;
      ly_q  <= in_i.left_y;
      rx_q  <= in_i.right_x;
      ry_q  <= in_i.right_y;
    end
  end

  // Physical levels: buttons, then left stick up/down/left/right, then right.
  logic [gpea_pkg::NumPhys-1:0] phys;

  assign phys = {gpea_pkg::axis_dir(rx_q, axis_lo_q, axis_hi_q),
                 gpea_pkg::axis_dir(ry_q, axis_lo_q, axis_hi_q),
                 gpea_pkg::axis_dir(lx_q, axis_lo_q, axis_hi_q),
                 gpea_pkg::axis_dir(ly_q, axis_lo_q, axis_hi_q),
                 btn_q};

  // One lane per physical input.
  gpea_pkg::rep_cfg_t  rep_cfg;
  gpea_pkg::lane_out_t lane_res [gpea_pkg::NumPhys];

  assign rep_cfg.delay  = delay_q;
  assign rep_cfg.reload = reload_q;

  for (genvar p = 0; p < gpea_pkg::NumPhys; p++) begin : g_lane
    gpea_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (advance),
      .cur_i  (phys[p]),
      .cfg_i  (rep_cfg),
      .res_o  (lane_res[p])
    );
  end

  // Spread lanes onto button indexes and fill in enter and cancel.
  gpea_pkg::res_t      res_d, res_q;
  gpea_pkg::lane_out_t enter_res, cancel_res;

  assign enter_res  = enter_circle_q ? lane_res[gpea_pkg::IdxCircle]
                                     : lane_res[gpea_pkg::IdxCross];
  assign cancel_res = enter_circle_q ? lane_res[gpea_pkg::IdxCross]
                                     : lane_res[gpea_pkg::IdxCircle];

  always_comb begin
    res_d = '0;
    for (int unsigned p = 0; p < gpea_pkg::NumPhys; p++) begin
      if (p < gpea_pkg::NumButtons) begin
        res_d.level_bits[p]       = lane_res[p].lvl;
        res_d.press_bits[p]       = lane_res[p].prs;
        res_d.release_bits[p]     = lane_res[p].rls;
        res_d.slow_repeat_bits[p] = lane_res[p].slw;
        res_d.fast_repeat_bits[p] = lane_res[p].fst;
      end else begin
        res_d.level_bits[p+2]       = lane_res[p].lvl;
        res_d.press_bits[p+2]       = lane_res[p].prs;
        res_d.release_bits[p+2]     = lane_res[p].rls;
        res_d.slow_repeat_bits[p+2] = lane_res[p].slw;
        res_d.fast_repeat_bits[p+2] = lane_res[p].fst;
      end
    end
    res_d.level_bits[gpea_pkg::IdxEnter]        = enter_res.lvl;
    res_d.press_bits[gpea_pkg::IdxEnter]        = enter_res.prs;
    res_d.release_bits[gpea_pkg::IdxEnter]      = enter_res.rls;
    res_d.slow_repeat_bits[gpea_pkg::IdxEnter]  = enter_res.slw;
    res_d.fast_repeat_bits[gpea_pkg::IdxEnter]  = enter_res.fst;
    res_d.level_bits[gpea_pkg::IdxCancel]       = cancel_res.lvl;
    res_d.press_bits[gpea_pkg::IdxCancel]       = cancel_res.prs;
    res_d.release_bits[gpea_pkg::IdxCancel]     = cancel_res.rls;
    res_d.slow_repeat_bits[gpea_pkg::IdxCancel] = cancel_res.slw;
    res_d.fast_repeat_bits[gpea_pkg::IdxCancel] = cancel_res.fst;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.level_bits       = res_q.level_bits;
  assign out_o.press_bits       = res_q.press_bits;
  assign out_o.release_bits     = res_q.release_bits;
  assign out_o.slow_repeat_bits = res_q.slow_repeat_bits;
  assign out_o.fast_repeat_bits = res_q.fast_repeat_bits;

`ifndef SYNTHESIS
  // A press and a release of the same button never share a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((res_q.press_bits & res_q.release_bits) == '0))
    else $error("press and release set together");

  // A press edge always shows as high level and on both repeat outputs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((res_q.press_bits & ~(res_q.level_bits & res_q.slow_repeat_bits
                    & res_q.fast_repeat_bits)) == '0))
    else $error("press edge missing from level or repeat outputs");

  // With both registers full and the receiver stalled, no new word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while pipeline is full");

  // A stalled result word is not overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> (out_vld_q && $stable(res_q)))
    else $error("stalled result word changed");
`endif

endmodule

/* tb/gpea_checker.sv */
// Scoreboard for the gamepad edge and auto-repeat block: watches both
// channels and the register port, predicts every result word and compares.
// Depends on gpea_pkg and the channel interfaces in gpea_if.sv.
`timescale 1ns / 1ps

module gpea_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gpea_in_if                            in_mon,
  gpea_out_if                           out_mon,
  input  logic                          cfg_we_i,
  input  logic [gpea_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gpea_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   pending_o
);

  // Shadow copy of the configuration registers.
  logic [gpea_pkg::AxisW-1:0]  axis_lo;
  logic [gpea_pkg::AxisW-1:0]  axis_hi;
  logic [gpea_pkg::DelayW-1:0] rep_delay;
  logic [gpea_pkg::DelayW-1:0] rep_reload;
  logic                        enter_circle;

  // Shadow copy of the per-input history.
  logic [gpea_pkg::NumPhys-1:0] prev_lvl;
  gpea_pkg::hold_cnt_t          slow_cnt [gpea_pkg::NumPhys];
  gpea_pkg::hold_cnt_t          fast_cnt [gpea_pkg::NumPhys];

  // Result words predicted but not yet seen on the output channel.
  gpea_pkg::res_t frame_results [$];
  gpea_pkg::res_t want;
  int unsigned    error_cnt = 0;

  // Two direction bits of one axis; the up or left side wins when the
  // limits cross.
  function automatic logic [1:0] stick_dir(input logic [gpea_pkg::AxisW-1:0] v);
    if (v < axis_lo) begin
      return 2'b01;
    end
    if (v > axis_hi) begin
      return 2'b10;
    end
    return 2'b00;
  endfunction

  // Enter and cancel follow circle or cross depending on the mode bit.
  function automatic gpea_pkg::out_vec_t map_keys(input gpea_pkg::out_vec_t v);
    gpea_pkg::out_vec_t m;
    m = v;
    m[gpea_pkg::IdxEnter]  = enter_circle ? v[gpea_pkg::IdxCircle] : v[gpea_pkg::IdxCross];
    m[gpea_pkg::IdxCancel] = enter_circle ? v[gpea_pkg::IdxCross]  : v[gpea_pkg::IdxCircle];
    return m;
  endfunction

  // Works out the result word of one sample and advances the history.
  function automatic gpea_pkg::res_t decode_frame(
      input logic [gpea_pkg::NumButtons-1:0] btn,
      input logic [gpea_pkg::AxisW-1:0] lx,
      input logic [gpea_pkg::AxisW-1:0] ly,
      input logic [gpea_pkg::AxisW-1:0] rx,
      input logic [gpea_pkg::AxisW-1:0] ry);
    logic [gpea_pkg::NumPhys-1:0] phys;
    logic                         cur;
    logic                         slw;
    logic                         fst;
    int unsigned                  o;
    gpea_pkg::res_t               r;
    phys = {stick_dir(rx), stick_dir(ry), stick_dir(lx), stick_dir(ly), btn};
    r = '0;
    for (int p = 0; p < gpea_pkg::NumPhys; p++) begin
      cur = phys[p];
      slw = cur & ~prev_lvl[p];
      fst = slw;
      if (cur) begin
        if (slow_cnt[p] >= rep_delay) begin
          slw = 1'b1;
          slow_cnt[p] = gpea_pkg::hold_cnt_t'(rep_reload);
        end
        if (fast_cnt[p] >= rep_delay) begin
          fst = 1'b1;
          fast_cnt[p] = gpea_pkg::hold_cnt_t'(rep_delay);
        end
        // Counters stick at their top value.
        if (slow_cnt[p] != '1) begin
          slow_cnt[p] = slow_cnt[p] + 1'b1;
        end
        if (fast_cnt[p] != '1) begin
          fast_cnt[p] = fast_cnt[p] + 1'b1;
        end
      end else begin
        slow_cnt[p] = '0;
        fast_cnt[p] = '0;
      end
      // Stick directions sit above the two mapped key positions.
      o = (p < gpea_pkg::NumButtons) ? p : p + (gpea_pkg::NumOut - gpea_pkg::NumPhys);
      r.level_bits[o]       = cur;
      r.press_bits[o]       = cur & ~prev_lvl[p];
      r.release_bits[o]     = ~cur & prev_lvl[p];
      r.slow_repeat_bits[o] = slw;
      r.fast_repeat_bits[o] = fst;
    end
    prev_lvl = phys;
    r.level_bits       = map_keys(r.level_bits);
    r.press_bits       = map_keys(r.press_bits);
    r.release_bits     = map_keys(r.release_bits);
    r.slow_repeat_bits = map_keys(r.slow_repeat_bits);
    r.fast_repeat_bits = map_keys(r.fast_repeat_bits);
    return r;
  endfunction

  task automatic check_field(input string name, input gpea_pkg::out_vec_t exp_v,
                             input gpea_pkg::out_vec_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %06h, actual %06h",
               $time, name, exp_v, act_v);
      error_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_lo      = gpea_pkg::AxisLowReset;
      axis_hi      = gpea_pkg::AxisHighReset;
      rep_delay    = gpea_pkg::DelayReset;
      rep_reload   = gpea_pkg::ReloadReset;
      enter_circle = 1'b1;
      prev_lvl     = '0;
      for (int p = 0; p < gpea_pkg::NumPhys; p++) begin
        slow_cnt[p] = '0;
        fast_cnt[p] = '0;
      end
      frame_results.delete();
      error_cnt = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      // Register writes; fields keep only their low bits.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gpea_pkg::CFG_AXIS_LOW:      axis_lo      = cfg_wdata_i[gpea_pkg::AxisW-1:0];
          gpea_pkg::CFG_AXIS_HIGH:     axis_hi      = cfg_wdata_i[gpea_pkg::AxisW-1:0];
          gpea_pkg::CFG_REPEAT_DELAY:  rep_delay    = cfg_wdata_i[gpea_pkg::DelayW-1:0];
          gpea_pkg::CFG_REPEAT_RELOAD: rep_reload   = cfg_wdata_i[gpea_pkg::DelayW-1:0];
          gpea_pkg::CFG_ENTER_CIRCLE:  enter_circle = cfg_wdata_i[0];
          default: ;
        endcase
      end

      // Compare every accepted result word with the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        if (frame_results.size() == 0) begin
          $display("%0t: result word with nothing expected: level %06h",
                   $time, out_mon.level_bits);
          error_cnt++;
        end else begin
          want = frame_results.pop_front();
          check_field("level_bits", want.level_bits, out_mon.level_bits);
          check_field("press_bits", want.press_bits, out_mon.press_bits);
          check_field("release_bits", want.release_bits, out_mon.release_bits);
          check_field("slow_repeat_bits", want.slow_repeat_bits,
                      out_mon.slow_repeat_bits);
          check_field("fast_repeat_bits", want.fast_repeat_bits,
                      out_mon.fast_repeat_bits);
        end
      end

      // Predict the result of every accepted sample word.
      if (in_mon.valid && in_mon.ready) begin
        frame_results.push_back(decode_frame(in_mon.digital_buttons,
                                             in_mon.left_x, in_mon.left_y,
                                             in_mon.right_x, in_mon.right_y));
      end

      fail_cnt_o <= error_cnt;
      pending_o  <= frame_results.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Top of the gamepad edge and auto-repeat testbench: clock, reset, sample
// stimulus, result back-pressure and the final verdict.
// Depends on gpea_pkg, gpea_if.sv, the block itself and gpea_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned NumPhases     = 14;
  localparam int unsigned ItemsPerPhase = 125;
  localparam int unsigned LongHoldOff   = 64;
  localparam int unsigned HoldOffEvery  = 600;
  localparam int unsigned DrainCycles   = 8;
  // First register index that maps to nothing.
  localparam logic [gpea_pkg::CfgIdxW-1:0] CfgIdxSpare =
      gpea_pkg::CfgIdxW'(gpea_pkg::CFG_ENTER_CIRCLE + 1);

  typedef struct packed {
    logic [gpea_pkg::NumButtons-1:0] btn;
    logic [gpea_pkg::AxisW-1:0]      lx;
    logic [gpea_pkg::AxisW-1:0]      ly;
    logic [gpea_pkg::AxisW-1:0]      rx;
    logic [gpea_pkg::AxisW-1:0]      ry;
  } frame_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [gpea_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [gpea_pkg::CfgDataW-1:0] cfg_wdata;
  int unsigned                   fail_cnt;
  int unsigned                   pending;
  int unsigned                   cycles = 0;
  int unsigned                   burst_left = 0;

  // Stimulus-side state: current limits and the controller being held.
  logic [gpea_pkg::AxisW-1:0]      cur_lo = gpea_pkg::AxisLowReset;
  logic [gpea_pkg::AxisW-1:0]      cur_hi = gpea_pkg::AxisHighReset;
  logic [gpea_pkg::NumButtons-1:0] held_btn = '0;
  logic [gpea_pkg::AxisW-1:0]      held_axis [4] = '{8'd128, 8'd128, 8'd128, 8'd128};

  gpea_in_if  sample_ch ();
  gpea_out_if result_ch ();

  gamepad_edge_autorepeat i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (sample_ch),
    .out_o       (result_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  gpea_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (sample_ch),
    .out_mon     (result_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result receiver: spans of random stall density, with a long hold-off
  // now and then so the input side backs up.
  initial begin : result_sink
    int unsigned span;
    int unsigned stall_pct;
    int unsigned since_hold;
    since_hold = 0;
    result_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      span = $urandom_range(4, 60);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (span) begin
        @(posedge clk_i);
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
      since_hold += span;
      if (since_hold >= HoldOffEvery) begin
        since_hold = 0;
        @(posedge clk_i);
        result_ch.ready <= 1'b0;
        repeat (LongHoldOff) @(posedge clk_i);
      end
    end
  end

  function automatic frame_t make_frame(input logic [gpea_pkg::NumButtons-1:0] btn,
                                        input logic [gpea_pkg::AxisW-1:0] lx,
                                        input logic [gpea_pkg::AxisW-1:0] ly,
                                        input logic [gpea_pkg::AxisW-1:0] rx,
                                        input logic [gpea_pkg::AxisW-1:0] ry);
    frame_t f;
    f.btn = btn;
    f.lx  = lx;
    f.ly  = ly;
    f.rx  = rx;
    f.ry  = ry;
    return f;
  endfunction

  // Axis values cluster at the ends and on both sides of each limit.
  function automatic logic [gpea_pkg::AxisW-1:0] pick_axis();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return cur_lo - 1'b1;
      3:       return cur_lo;
      4:       return cur_hi;
      5:       return cur_hi + 1'b1;
      default: return gpea_pkg::AxisW'($urandom);
    endcase
  endfunction

  // Mostly a held controller that changes slowly, sometimes pure noise.
  function automatic frame_t next_frame(input int unsigned flip_odds);
    if ($urandom_range(0, 9) == 0) begin
      return make_frame(gpea_pkg::NumButtons'($urandom), gpea_pkg::AxisW'($urandom),
                        gpea_pkg::AxisW'($urandom), gpea_pkg::AxisW'($urandom),
                        gpea_pkg::AxisW'($urandom));
    end
    for (int b = 0; b < gpea_pkg::NumButtons; b++) begin
      if ($urandom_range(0, flip_odds) == 0) begin
        held_btn[b] = ~held_btn[b];
      end
    end
    for (int a = 0; a < 4; a++) begin
      if ($urandom_range(0, flip_odds) == 0) begin
        held_axis[a] = pick_axis();
      end
    end
    return make_frame(held_btn, held_axis[0], held_axis[1], held_axis[2],
                      held_axis[3]);
  endfunction

  // Presents one word and returns at the edge that accepts it.
  task automatic put_frame(input frame_t f);
    sample_ch.valid           <= 1'b1;
    sample_ch.digital_buttons <= f.btn;
    sample_ch.left_x          <= f.lx;
    sample_ch.left_y          <= f.ly;
    sample_ch.right_x         <= f.rx;
    sample_ch.right_y         <= f.ry;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
  endtask

  // Sends in bursts of random length separated by random gaps.
  task automatic offer(input frame_t f);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    put_frame(f);
  endtask

  // Stops sending until every predicted word has come out.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [gpea_pkg::CfgIdxW-1:0] idx,
                         input logic [gpea_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Writes every register, with junk in the unused upper bits, and one
  // write to an index that maps to nothing.
  task automatic write_settings(input logic [gpea_pkg::AxisW-1:0] lo,
                                input logic [gpea_pkg::AxisW-1:0] hi,
                                input logic [gpea_pkg::DelayW-1:0] dly,
                                input logic [gpea_pkg::DelayW-1:0] rld,
                                input logic ent);
    logic [gpea_pkg::CfgDataW-1:0] junk;
    junk = gpea_pkg::CfgDataW'($urandom);
    put_reg(gpea_pkg::CFG_AXIS_LOW, lo);
    put_reg(gpea_pkg::CFG_AXIS_HIGH, hi);
    put_reg(gpea_pkg::CFG_REPEAT_DELAY, {junk[gpea_pkg::CfgDataW-1:gpea_pkg::DelayW], dly});
    junk = gpea_pkg::CfgDataW'($urandom);
    put_reg(gpea_pkg::CFG_REPEAT_RELOAD, {junk[gpea_pkg::CfgDataW-1:gpea_pkg::DelayW], rld});
    junk = gpea_pkg::CfgDataW'($urandom);
    put_reg(gpea_pkg::CFG_ENTER_CIRCLE, {junk[gpea_pkg::CfgDataW-1:1], ent});
    put_reg(gpea_pkg::CfgIdxW'($urandom_range(CfgIdxSpare, (1 << gpea_pkg::CfgIdxW) - 1)),
            gpea_pkg::CfgDataW'($urandom));
    cfg_we <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  initial begin : stimulus
    int unsigned                flip_odds;
    logic [gpea_pkg::AxisW-1:0] lo;
    logic [gpea_pkg::AxisW-1:0] hi;
    rst_ni                    <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_idx                   <= gpea_pkg::CFG_AXIS_LOW;
    cfg_wdata                 <= '0;
    sample_ch.valid           <= 1'b0;
    sample_ch.digital_buttons <= '0;
    sample_ch.left_x          <= '0;
    sample_ch.left_y          <= '0;
    sample_ch.right_x         <= '0;
    sample_ch.right_y         <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: centered sticks, everything
    // held past the repeat delay, release, limits on both sides, mapped keys.
    offer(make_frame('0, 8'd128, 8'd128, 8'd128, 8'd128));
    repeat (13) offer(make_frame('1, '0, '0, '0, '0));
    offer(make_frame('0, '1, '1, '1, '1));
    offer(make_frame(gpea_pkg::NumButtons'(1 << gpea_pkg::IdxCircle), cur_lo - 1'b1,
                     cur_lo, cur_hi, cur_hi + 1'b1));
    offer(make_frame(gpea_pkg::NumButtons'(1 << gpea_pkg::IdxCross), cur_lo,
                     cur_lo - 1'b1, cur_hi + 1'b1, cur_hi));
    offer(make_frame(12'h555, 8'd128, '0, '1, 8'd128));
    offer(make_frame(12'hAAA, '1, 8'd128, 8'd128, '0));
    offer(make_frame('0, '0, '1, '1, '0));
    drain();

    // Random phases: the first few use the extreme settings, the rest are
    // drawn at random.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: write_settings('0, '1, 4'd1, 4'd0, 1'b0);
        1: write_settings('1, '0, 4'd0, 4'd0, 1'b1);
        2: write_settings(8'd128, 8'd127, '1, '1, 1'b0);
        3: write_settings(8'd1, 8'd254, '1, '0, 1'b1);
        4: write_settings(gpea_pkg::AxisLowReset, gpea_pkg::AxisHighReset, 4'd3, 4'd7,
                          1'b0);
        default: begin
          lo = gpea_pkg::AxisW'($urandom);
          hi = gpea_pkg::AxisW'($urandom);
          // Mostly sane limits, now and then crossed ones.
          if (lo > hi && $urandom_range(0, 3) != 0) begin
            {lo, hi} = {hi, lo};
          end
          write_settings(lo, hi,
                         ($urandom_range(0, 2) == 0)
                             ? gpea_pkg::DelayW'($urandom)
                             : gpea_pkg::DelayW'($urandom_range(1, 5)),
                         gpea_pkg::DelayW'($urandom), 1'($urandom));
        end
      endcase
      flip_odds = (ph == 2 || ph == 3) ? 40 : $urandom_range(3, 32);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        offer(next_frame(flip_odds));
      end
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
